>>> rtl/wsup_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsup_pkg
// Shared types and constants for the wide string to unsigned parser.
// ---------------------------------------------------------------------------
package wsup_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam int CHAR_W  = 21;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 64;
  localparam int END_W   = 16;

  // Stream data widths, rounded up to whole bytes.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 88;

  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] DIGIT_TEN  = 6'd10;

  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 21'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 21'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 21'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 21'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 21'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 21'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 21'h7A;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] d;
  } digit_t;

  typedef struct packed {
    logic               converted;
    logic               range_error;
    logic [END_W-1:0]   end_position;
    logic [VALUE_W-1:0] value;
  } result_t;

  // Digit value of a character: 0-9, then letters of either case as 10 to 35.
  function automatic digit_t digit_of(logic [CHAR_W-1:0] c);
    digit_t r;
    r.ok = 1'b0;
    r.d  = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r.ok = 1'b1;
      r.d  = BASE_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      r.ok = 1'b1;
      r.d  = BASE_W'(c - CH_LA) + DIGIT_TEN;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      r.ok = 1'b1;
      r.d  = BASE_W'(c - CH_UA) + DIGIT_TEN;
    end
    return r;
  endfunction

endpackage

>>> rtl/wsup_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsup_step
// Parser state and the combinational step that consumes one character.
// ---------------------------------------------------------------------------
module wsup_step import wsup_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CHAR_W-1:0] wide_char,
  input  logic              is_last,
  input  logic [BASE_W-1:0] number_base,
  output logic              res_emit,
  output result_t           res
);

  localparam int EXT = (POSITION_BITS > END_W) ? POSITION_BITS : END_W;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_HEXMARK,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                   phase;
  logic [BASE_W-1:0]        active_base;
  logic [VALUE_W-1:0]       accumulator;
  logic [POSITION_BITS-1:0] position;
  logic                     any_digit;

  phase_t                   phase_next;
  logic [BASE_W-1:0]        active_base_next;
  logic [VALUE_W-1:0]       accumulator_next;
  logic                     any_digit_next;
  logic [POSITION_BITS-1:0] position_next;

  logic                     cont;
  logic                     emit1;
  logic                     emit2;
  result_t                  res1;
  result_t                  res2;
  digit_t                   dig;
  logic [VALUE_W+BASE_W-1:0] mac;
  logic                     is_space;

  // Saturate a position to the 16-bit result field.
  function automatic logic [END_W-1:0] sat_end(logic [POSITION_BITS-1:0] p);
    logic [EXT:0] w;
    w = (EXT+1)'(p);
    if (w > (EXT+1)'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return w[END_W-1:0];
  endfunction

  assign dig      = digit_of(wide_char);
  assign is_space = (wide_char == CH_SPACE) || (wide_char >= CH_TAB && wide_char <= CH_CR);
  assign mac      = (VALUE_W+BASE_W)'(accumulator) * (VALUE_W+BASE_W)'(active_base)
                  + (VALUE_W+BASE_W)'(dig.d);
  assign position_next = (position == '1) ? position : position + 1'b1;

  always_comb begin
    phase_next       = phase;
    active_base_next = active_base;
    accumulator_next = accumulator;
    any_digit_next   = any_digit;
    cont             = (phase != PH_DONE);
    emit1            = 1'b0;
    res1             = '0;

    if (cont && phase_next == PH_SPACE) begin
      if (is_space) begin
        cont = 1'b0;
      end else if (wide_char == CH_PLUS) begin
        phase_next = PH_START;
        cont       = 1'b0;
      end else if (wide_char == CH_MINUS) begin
        emit1            = 1'b1;
        res1.range_error = 1'b1;
        cont             = 1'b0;
      end else begin
        phase_next = PH_START;
      end
    end

    if (cont && phase_next == PH_START) begin
      if ((number_base == BASE_AUTO || number_base == BASE_HEX) && wide_char == CH_0) begin
        active_base_next = number_base;
        accumulator_next = '0;
        any_digit_next   = 1'b1;
        phase_next       = PH_ZERO;
        cont             = 1'b0;
      end else begin
        active_base_next = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
        phase_next       = PH_DIGITS;
      end
    end

    if (cont && phase_next == PH_ZERO) begin
      if (wide_char == CH_LX || wide_char == CH_UX) begin
        active_base_next = BASE_HEX;
        phase_next       = PH_HEXMARK;
        cont             = 1'b0;
      end else begin
        if (active_base_next == BASE_AUTO) begin
          active_base_next = BASE_OCT;
        end
        phase_next = PH_DIGITS;
      end
    end

    if (cont && phase_next == PH_HEXMARK) begin
      if (dig.ok && dig.d < BASE_HEX) begin
        phase_next = PH_DIGITS;
      end else begin
        // The "0x" alone: the zero was the number, the x is left over.
        emit1             = 1'b1;
        res1.converted    = 1'b1;
        res1.end_position = sat_end((position != '0) ? position - 1'b1 : position);
        cont              = 1'b0;
      end
    end

    if (cont) begin
      // Digit phase. The multiply-add uses the base held in the register, which
      // differs from the final base only while the accumulator is still zero.
      if (active_base_next >= BASE_MIN && active_base_next <= BASE_MAX && dig.ok
          && dig.d < active_base_next) begin
        if (mac[VALUE_W+BASE_W-1:VALUE_W] != '0) begin
          emit1             = 1'b1;
          res1.value        = '1;
          res1.end_position = sat_end(position);
          res1.range_error  = 1'b1;
          res1.converted    = 1'b1;
        end else begin
          accumulator_next = mac[VALUE_W-1:0];
          any_digit_next   = 1'b1;
        end
      end else begin
        emit1             = 1'b1;
        res1.value        = accumulator_next;
        res1.end_position = any_digit_next ? sat_end(position) : '0;
        res1.converted    = any_digit_next;
      end
    end
  end

  // End of string before the conversion finished: behave as if a NUL followed.
  always_comb begin
    emit2             = is_last && !emit1 && (phase_next != PH_DONE);
    res2              = '0;
    res2.value        = accumulator_next;
    res2.converted    = any_digit_next;
    if (any_digit_next) begin
      res2.end_position = (phase_next == PH_HEXMARK) ? sat_end(position_next - 1'b1)
                                                     : sat_end(position_next);
    end
  end

  assign res_emit = emit1 || emit2;
  assign res      = emit1 ? res1 : res2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      active_base <= '0;
      accumulator <= '0;
      position    <= '0;
      any_digit   <= 1'b0;
    end else if (fire) begin
      if (is_last) begin
        phase       <= PH_SPACE;
        active_base <= '0;
        accumulator <= '0;
        position    <= '0;
        any_digit   <= 1'b0;
      end else begin
        phase       <= emit1 ? PH_DONE : phase_next;
        active_base <= active_base_next;
        accumulator <= accumulator_next;
        position    <= position_next;
        any_digit   <= any_digit_next;
      end
    end
  end

endmodule

>>> rtl/wide_string_to_unsigned_parser_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wide_string_to_unsigned_parser_core
// Streams a wide string one code point per transaction and returns its
// leading unsigned number as a 64-bit value, strtoull style.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Carries
// --------  ---------  ------------------------------------------------------
// s_axis    in         one character: tdata = wide_char, tlast = is_last
// m_axis    out        one result per string: value, end_position,
//                      range_error, converted
// cfg       in         number_base, written when cfg_wen is high
//
// The step stage consumes one character at a time, and a new character can
// be accepted every cycle while the result register does not stall. The loop
// that sets this rate is the 64 by 6 bit multiply-add with overflow check
// that updates the accumulator. An accepted character is held in the input
// register, then its result in the result register. Reset clears the parser
// to the white space phase and sets number_base to 10. When the result
// register is full and not taken, the step stage holds and s_axis_tready
// drops once the input register is also occupied.
// ---------------------------------------------------------------------------
module wide_string_to_unsigned_parser_core import wsup_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [20:0] wide_char, rest zero
  input  logic                s_axis_tlast,   // is_last

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // [63:0] value, [79:64] end_position,
                                              // [80] range_error, [81] converted,
                                              // rest zero

  input  logic                cfg_wen,
  input  logic [BASE_W-1:0]   cfg_wdata       // number_base
);

  // Configuration register.
  logic [BASE_W-1:0] number_base;

  // Input register.
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // Result register.
  logic              out_valid;
  result_t           out_res;

  logic              fire;
  logic              res_emit;
  result_t           res;

  // The step stage runs whenever a character waits and the result register
  // can take whatever that character produces.
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_DEC;
    end else if (cfg_wen) begin
      number_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata[CHAR_W-1:0];
      in_last <= s_axis_tlast;
    end
  end

  wsup_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .wide_char   (in_char),
    .is_last     (in_last),
    .number_base (number_base),
    .res_emit    (res_emit),
    .res         (res)
  );

  // A result transaction is loaded only when the register is free or being
  // drained in the same cycle, which fire already guarantees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_DATA_W'(out_res);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for wide_string_to_unsigned_parser_core. Strings are
// streamed one code point per transaction. A behavioral parser in this file
// predicts the one result of each string, and every result transaction is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module testbench import wsup_pkg::*; ();

  localparam logic [BASE_W-1:0] BASE_NONE      = 6'd1;      // accepts no digit
  localparam logic [CHAR_W-1:0] CH_NUL         = 21'h0;
  localparam logic [CHAR_W-1:0] CODE_POINT_MAX = 21'h10FFFF;
  localparam int unsigned       NO_DIGIT       = 99;
  localparam int unsigned       LONG_RUN       = 300;       // past an 8-bit count
  localparam int unsigned       PHASE_CHARS    = 200;
  localparam int unsigned       SETTLE_CYCLES  = 6;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGNED, SCAN_ZERO, SCAN_HEX_MARK, SCAN_DIGITS, SCAN_FINISHED
  } scan_phase_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;   // [20:0] wide_char
  logic                s_axis_tlast = 1'b0; // is_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // [63:0] value, [79:64] end_position,
                                            // [80] range_error, [81] converted
  logic                cfg_wen = 1'b0;
  logic [BASE_W-1:0]   cfg_wdata = BASE_DEC;

  wide_string_to_unsigned_parser_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the configured radix and of the parser.
  logic [BASE_W-1:0] radix_cfg;
  scan_phase_t       scan_phase;
  logic [BASE_W-1:0] scan_radix;
  logic [63:0]       scan_acc;
  logic [END_W-1:0]  scan_pos;
  bit                scan_any;

  result_t           expected_results[$];
  logic [CHAR_W-1:0] char_buf[$];
  int unsigned       mismatches = 0;

  // Idle control shared by the sender task and the receiver process.
  bit                source_gaps_on = 1'b1;
  bit                sink_stalls_on = 1'b1;
  int unsigned       sink_hold_req = 0;
  int unsigned       sink_wait;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic void restart_scan();
    scan_phase = SCAN_BLANK;
    scan_radix = '0;
    scan_acc   = '0;
    scan_pos   = '0;
    scan_any   = 1'b0;
  endfunction

  // Digit weight of a code point, or NO_DIGIT when it is no digit at all.
  function automatic int unsigned char_weight(logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return 32'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return 32'(c - CH_UA) + 10;
    return NO_DIGIT;
  endfunction

  // One character at index pos. Returns 1 when the conversion ends here and
  // the result is in r.
  function automatic bit scan_char(logic [CHAR_W-1:0] c, logic [END_W-1:0] pos,
                                   output result_t r);
    int unsigned d;
    logic [63:0] headroom;
    r = '0;
    if (scan_phase == SCAN_FINISHED) return 1'b0;
    if (scan_phase == SCAN_BLANK) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return 1'b0;
      if (c == CH_PLUS) begin
        scan_phase = SCAN_SIGNED;
        return 1'b0;
      end
      if (c == CH_MINUS) begin
        // A minus sign ends the conversion with nothing consumed.
        r.range_error = 1'b1;
        return 1'b1;
      end
      scan_phase = SCAN_SIGNED;
    end
    if (scan_phase == SCAN_SIGNED) begin
      if ((radix_cfg == BASE_AUTO || radix_cfg == BASE_HEX) && c == CH_0) begin
        // The leading zero already counts as a converted digit.
        scan_radix = radix_cfg;
        scan_acc   = '0;
        scan_any   = 1'b1;
        scan_phase = SCAN_ZERO;
        return 1'b0;
      end
      scan_radix = (radix_cfg == BASE_AUTO) ? BASE_DEC : radix_cfg;
      scan_phase = SCAN_DIGITS;
    end
    if (scan_phase == SCAN_ZERO) begin
      if (c == CH_LX || c == CH_UX) begin
        scan_radix = BASE_HEX;
        scan_phase = SCAN_HEX_MARK;
        return 1'b0;
      end
      if (scan_radix == BASE_AUTO) scan_radix = BASE_OCT;
      scan_phase = SCAN_DIGITS;
    end
    if (scan_phase == SCAN_HEX_MARK) begin
      if (char_weight(c) < BASE_HEX) begin
        scan_phase = SCAN_DIGITS;
      end else begin
        // "0x" with no hex digit after it: only the zero was consumed.
        r.converted    = 1'b1;
        r.end_position = (pos != '0) ? pos - 1'b1 : '0;
        return 1'b1;
      end
    end
    d = char_weight(c);
    if (scan_radix >= BASE_MIN && scan_radix <= BASE_MAX && d < scan_radix) begin
      headroom = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(scan_radix);
      if (scan_acc > headroom) begin
        r.value        = '1;
        r.end_position = pos;
        r.range_error  = 1'b1;
        r.converted    = 1'b1;
        return 1'b1;
      end
      scan_acc = scan_acc * 64'(scan_radix) + 64'(d);
      scan_any = 1'b1;
      return 1'b0;
    end
    r.value        = scan_acc;
    r.end_position = scan_any ? pos : '0;
    r.converted    = scan_any;
    return 1'b1;
  endfunction

  // Predicts one accepted character transaction. Returns 1 when it yields
  // a result.
  function automatic bit predict_char(logic [CHAR_W-1:0] c, bit last, output result_t r);
    bit done;
    done = scan_char(c, scan_pos, r);
    if (scan_pos != '1) scan_pos = scan_pos + 1'b1;
    if (done) begin
      scan_phase = SCAN_FINISHED;
    end else if (last && scan_phase != SCAN_FINISHED) begin
      // The string ends early: finish as if a NUL followed.
      done = scan_char(CH_NUL, scan_pos, r);
    end
    if (last) restart_scan();
    return done;
  endfunction

  // -------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then long.
  // -------------------------------------------------------------------------
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (!source_gaps_on || $urandom_range(0, 99) < 60) return 0;
    return idle_length();
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  task automatic push_char(input logic [CHAR_W-1:0] c, input bit last);
    int unsigned gap;
    result_t     r;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(c);
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (predict_char(c, last, r)) expected_results.push_back(r);
  endtask

  // Sends the buffered string, marking its final character as the last one.
  task automatic send_chars();
    for (int i = 0; i < char_buf.size(); i++) push_char(char_buf[i], i == char_buf.size() - 1);
    char_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(CHAR_W'(s[i]));
    send_chars();
  endtask

  // Stops offering and waits until every predicted result has arrived. The
  // extra cycles cover trailing characters that produce no result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [BASE_W-1:0] b);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    radix_cfg = b;
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (sink_hold_req != 0) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= sink_hold_req - 1;
      sink_hold_req  = 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= idle_length() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    // Keep the log readable when the design is badly broken.
    if (mismatches <= 100)
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Each result transaction is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, value", got.value, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.end_position !== want.end_position)
          report_mismatch("end_position", 64'(got.end_position), 64'(want.end_position));
        if (got.range_error !== want.range_error)
          report_mismatch("range_error", 64'(got.range_error), 64'(want.range_error));
        if (got.converted !== want.converted)
          report_mismatch("converted", 64'(got.converted), 64'(want.converted));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Random strings
  // -------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] random_code_point();
    if ($urandom_range(0, 1) == 0) return CHAR_W'($urandom_range(0, 127));
    return CHAR_W'($urandom_range(0, CODE_POINT_MAX));
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned v);
    if (v < 10) return CH_0 + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CHAR_W'(v - 10);
  endfunction

  // Mostly well-formed numbers for the current radix: optional white space,
  // sign and prefix, then digits and some trailing junk. A few strings are
  // pure noise.
  task automatic build_random_string();
    int unsigned n;
    int unsigned roll;
    int unsigned eff;
    char_buf.delete();
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) char_buf.push_back(random_code_point());
      return;
    end
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n)
      char_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB + CHAR_W'($urandom_range(0, 4)));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      char_buf.push_back(CH_PLUS);
    end else if (roll < 15) begin
      char_buf.push_back(CH_MINUS);
    end else if (roll < 17) begin
      char_buf.push_back(CH_PLUS);
      char_buf.push_back(CH_PLUS);
    end
    eff = (radix_cfg == BASE_AUTO) ? BASE_DEC : radix_cfg;
    if (radix_cfg == BASE_AUTO || radix_cfg == BASE_HEX) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        char_buf.push_back(CH_0);
        char_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        eff = BASE_HEX;
      end else if (roll < 50 && radix_cfg == BASE_AUTO) begin
        char_buf.push_back(CH_0);
        eff = BASE_OCT;
      end
    end
    // Long digit runs are what drive the accumulator into overflow.
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
    repeat (n)
      char_buf.push_back(digit_char(eff < BASE_MIN ? $urandom_range(0, 35)
                                                   : $urandom_range(0, eff - 1)));
    if ($urandom_range(0, 9) == 0) char_buf.push_back(digit_char($urandom_range(0, 35)));
    n = $urandom_range(0, 3);
    repeat (n) char_buf.push_back(random_code_point());
    if (char_buf.size() == 0) char_buf.push_back(random_code_point());
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Radix 10 straight out of reset: white space and plus sign, a minus sign
  // with an ignored tail, and a sign with no digits.
  task automatic test_default_radix();
    send_text(" \t+7");
    send_text("-5");
    send_text("+");
  endtask

  // Auto-detected radix: hex prefix, octal, a lone zero, and "0x" followed
  // by something that is no hex digit.
  task automatic test_auto_radix();
    set_radix(BASE_AUTO);
    send_text("0x1f");
    send_text("017");
    send_text("0");
    send_text("0xg");
  endtask

  // Explicit radix 16 with a bare "0X", and a radix that accepts no digit.
  task automatic test_odd_radix();
    set_radix(BASE_HEX);
    send_text("0X");
    set_radix(BASE_NONE);
    send_text("5");
  endtask

  // Radix 36: overflow on the thirteenth digit, the highest code point, and
  // a NUL in the middle of a string.
  task automatic test_wide_radix();
    set_radix(BASE_MAX);
    send_text("zzzzzzzzzzzzz");
    char_buf.push_back(CODE_POINT_MAX);
    send_chars();
    char_buf.push_back(CHAR_W'("4"));
    char_buf.push_back(CH_NUL);
    char_buf.push_back(CHAR_W'("9"));
    send_chars();
  endtask

  // A long run of leading zeros, so that the position counter runs well
  // past a single byte before the number ends.
  task automatic test_long_run();
    set_radix(BASE_DEC);
    source_gaps_on = 1'b0;
    repeat (LONG_RUN) char_buf.push_back(CH_0);
    char_buf.push_back(CHAR_W'("7"));
    char_buf.push_back(CHAR_W'(";"));
    send_chars();
    source_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while one-digit strings keep
  // coming, so the pipeline fills and input transactions stall. Afterwards
  // the sender pauses until every result is back.
  task automatic test_backpressure();
    set_radix(BASE_DEC);
    source_gaps_on = 1'b0;
    sink_hold_req  = 200;
    for (int i = 0; i < 40; i++) begin
      char_buf.push_back(digit_char(i % 10));
      send_chars();
    end
    drain_results();
    source_gaps_on = 1'b1;
  endtask

  // Random strings over several radix settings, the extremes among them.
  // Every third phase runs with no idling on either side.
  task automatic test_random_strings();
    logic [BASE_W-1:0] radix_list[8];
    int unsigned       sent;
    radix_list = '{BASE_MIN, BASE_OCT, BASE_DEC, BASE_HEX, BASE_MAX, BASE_AUTO,
                   BASE_W'($urandom_range(0, BASE_MAX)), BASE_W'($urandom_range(0, BASE_MAX))};
    for (int p = 0; p < 8; p++) begin
      set_radix(radix_list[p]);
      source_gaps_on = (p % 3 != 2);
      sink_stalls_on = (p % 3 != 2);
      sent = 0;
      while (sent < PHASE_CHARS) begin
        build_random_string();
        sent += char_buf.size();
        send_chars();
      end
    end
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin : run_tests
    radix_cfg = BASE_DEC;
    restart_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_radix();
    test_auto_radix();
    test_odd_radix();
    test_wide_radix();
    test_backpressure();
    test_random_strings();
    test_long_run();
    drain_results();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, with the longest idles on both sides.
  initial begin : watchdog
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
